// ===== src/timed_action_table_defines.svh =====
// ----------------------------------------------------------------------------
// timed_action_table_defines.svh
// Assertion macros for the timed action table checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_ACTION_TABLE_DEFINES_SVH
`define TIMED_ACTION_TABLE_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define TAT_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// tat_pkg
// Types and constants shared by the timed action table modules.
// ----------------------------------------------------------------------------
package tat_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_W           = $clog2(MAX_RESULTS + 1);

   localparam int ACTION_W  = 2;
   localparam int TIME_W    = 32;
   localparam int NOTE_CH_W = 4;
   localparam int PITCH_W   = 7;
   localparam int TCHAN_W   = 10;
   localparam int TVAL_W    = 8;
   localparam int DELAY_W   = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SCHEDULE = 2'd0,
      ACT_CANCEL   = 2'd1,
      ACT_CHECK    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } ctl_state_type;

   // one table entry as held in slot memory
   typedef struct packed {
      logic [NOTE_CH_W-1:0] note_channel;
      logic [PITCH_W-1:0]   note_pitch;
      logic [TCHAN_W-1:0]   target_channel;
      logic [TVAL_W-1:0]    target_value;
      logic [TIME_W-1:0]    deadline;
   } slot_type;

   typedef struct packed {
      logic write;   // schedule: store request at ring pointer
      logic start;   // cancel/check: latch request, restart scan
      logic scan;    // scan in progress
      logic flush;   // move held result to output as final word
   } tat_cmd_type;

   typedef struct packed {
      logic scan_end;    // all slots seen (or result cap hit), pipe empty
      logic pend_valid;  // a result is held back waiting for its last flag
      logic out_free;    // output register can load this cycle
   } tat_sts_type;

endpackage

// ===== src/timed_action_table.sv =====
// ----------------------------------------------------------------------------
// timed_action_table
// Table of pending timed actions: schedule, cancel by note key, check expiry.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake              Word
//   req_     in   req_valid / req_ready  action, now, note key, target, delay
//   rsp_     out  rsp_valid / rsp_ready  out_channel, out_value, last
//
// A schedule is stored as it is accepted; cancel and check run a slot scan (accept,
// one memory read per slot, last compare, scan end, final-word drain), the
// slot scan reading one memory entry per cycle unless a check stall holds it.
// A check stalls its scan when a second expired slot is found while the
// output register still holds an untaken word.
// A new request is taken while the final word of the last check waits.
// Reset is synchronous, active high; no clearing pass is needed, valid bits
// reset at once.
//
module timed_action_table #(
   parameter int ENTRIES = tat_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tat_pkg::ACTION_W-1:0]  req_action,
   input  logic [tat_pkg::TIME_W-1:0]    req_now,
   input  logic [tat_pkg::NOTE_CH_W-1:0] req_note_channel,
   input  logic [tat_pkg::PITCH_W-1:0]   req_note_pitch,
   input  logic [tat_pkg::TCHAN_W-1:0]   req_target_channel,
   input  logic [tat_pkg::TVAL_W-1:0]    req_target_value,
   input  logic [tat_pkg::DELAY_W-1:0]   req_delay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tat_pkg::TCHAN_W-1:0]   rsp_out_channel,
   output logic [tat_pkg::TVAL_W-1:0]    rsp_out_value,
   output logic                          rsp_last
);
   import tat_pkg::*;

   tat_cmd_type cmd;
   tat_sts_type sts;

   // sequencer: owns the request handshake and the scan phases
   tat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and scan pipe; one expired result is held back so the
   // last flag can be set once the scan knows no more follow
   tat_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_now            (req_now),
      .req_note_channel   (req_note_channel),
      .req_note_pitch     (req_note_pitch),
      .req_target_channel (req_target_channel),
      .req_target_value   (req_target_value),
      .req_delay          (req_delay),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_value      (rsp_out_value),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== src/tat_ctrl.sv =====
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer: accepts one request, runs the slot scan, drains the final word.
// ----------------------------------------------------------------------------
module tat_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [tat_pkg::ACTION_W-1:0] req_action,
   output logic                      req_ready,
   input  tat_pkg::tat_sts_type      sts,
   output tat_pkg::tat_cmd_type      cmd
);
   import tat_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_action)
                  ACT_SCHEDULE: begin
                     cmd.write = 1'b1;
                  end
                  ACT_CANCEL, ACT_CHECK: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     // unused code: consumed, no effect
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/tat_datapath.sv =====
// ----------------------------------------------------------------------------
// tat_datapath
// Slot memory, valid bits, ring pointer, scan pipe and result registers.
// ----------------------------------------------------------------------------
module tat_datapath #(
   parameter int ENTRIES = tat_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tat_pkg::tat_cmd_type          cmd,
   output tat_pkg::tat_sts_type          sts,
   input  logic [tat_pkg::ACTION_W-1:0]  req_action,
   input  logic [tat_pkg::TIME_W-1:0]    req_now,
   input  logic [tat_pkg::NOTE_CH_W-1:0] req_note_channel,
   input  logic [tat_pkg::PITCH_W-1:0]   req_note_pitch,
   input  logic [tat_pkg::TCHAN_W-1:0]   req_target_channel,
   input  logic [tat_pkg::TVAL_W-1:0]    req_target_value,
   input  logic [tat_pkg::DELAY_W-1:0]   req_delay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tat_pkg::TCHAN_W-1:0]   rsp_out_channel,
   output logic [tat_pkg::TVAL_W-1:0]    rsp_out_value,
   output logic                          rsp_last
);
   import tat_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   slot_type mem [ENTRIES];

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [RES_W-1:0]   cnt_ff, cnt_in;
   logic               ev_valid_ff, ev_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload, no reset
   slot_type             rd_q_ff;
   logic [IDX_W-1:0]     ev_idx_ff;
   logic                 check_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [NOTE_CH_W-1:0] key_ch_ff;
   logic [PITCH_W-1:0]   key_pitch_ff;
   logic [TCHAN_W-1:0]   pend_ch_ff;
   logic [TVAL_W-1:0]    pend_val_ff;
   logic [TCHAN_W-1:0]   rsp_ch_ff;
   logic [TVAL_W-1:0]    rsp_val_ff;
   logic                 rsp_last_ff;

   slot_type slot_new;
   logic     issue_end, cap_hit, key_hit, due, hit, out_free, stall, issue, take, move;

   always_comb begin
      slot_new.note_channel   = req_note_channel;
      slot_new.note_pitch     = req_note_pitch;
      slot_new.target_channel = req_target_channel;
      slot_new.target_value   = req_target_value;
      slot_new.deadline       = req_now + TIME_W'(req_delay);

      issue_end = (rd_idx_ff == CNT_W'(ENTRIES));
      cap_hit   = (cnt_ff == RES_W'(MAX_RESULTS));
      key_hit   = (rd_q_ff.note_channel == key_ch_ff) && (rd_q_ff.note_pitch == key_pitch_ff);
      due       = (rd_q_ff.deadline <= now_ff);
      hit       = ev_valid_ff && valid_ff[ev_idx_ff] && !cap_hit && (check_ff ? due : key_hit);
      out_free  = !rsp_valid_ff || rsp_ready;
      // second hit with a held result and a full output: freeze the pipe
      stall     = hit && check_ff && pend_valid_ff && !out_free;
      issue     = cmd.scan && !issue_end && !cap_hit && !stall;
      take      = hit && !stall;
      move      = take && check_ff && pend_valid_ff;

      valid_in = valid_ff;
      if (cmd.write) begin
         valid_in[wr_ptr_ff] = 1'b1;
      end
      if (take) begin
         valid_in[ev_idx_ff] = 1'b0;
      end

      wr_ptr_in = wr_ptr_ff;
      if (cmd.write) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end

      rd_idx_in = cmd.start ? '0 : (issue ? rd_idx_ff + 1'b1 : rd_idx_ff);

      ev_valid_in = cmd.start ? 1'b0 : (stall ? ev_valid_ff : issue);

      cnt_in = cnt_ff;
      if (cmd.start) begin
         cnt_in = '0;
      end else if (take && check_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end

      pend_valid_in = pend_valid_ff;
      if (cmd.start || cmd.flush) begin
         pend_valid_in = 1'b0;
      end else if (take && check_ff) begin
         pend_valid_in = 1'b1;
      end

      rsp_valid_in = (move || cmd.flush) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      sts.scan_end   = (issue_end || cap_hit) && !ev_valid_ff;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_idx_ff     <= '0;
         cnt_ff        <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_idx_ff     <= rd_idx_in;
         cnt_ff        <= cnt_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[wr_ptr_ff] <= slot_new;
      end
      if (issue) begin
         rd_q_ff   <= mem[rd_idx_ff[IDX_W-1:0]];
         ev_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         check_ff     <= (req_action == ACT_CHECK);
         now_ff       <= req_now;
         key_ch_ff    <= req_note_channel;
         key_pitch_ff <= req_note_pitch;
      end
      if (take && check_ff) begin
         pend_ch_ff  <= rd_q_ff.target_channel;
         pend_val_ff <= rd_q_ff.target_value;
      end
      if (move) begin
         rsp_ch_ff   <= pend_ch_ff;
         rsp_val_ff  <= pend_val_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.flush) begin
         rsp_ch_ff   <= pend_ch_ff;
         rsp_val_ff  <= pend_val_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_out_value   = rsp_val_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== src/tat_checker.sv =====
// ----------------------------------------------------------------------------
// tat_checker
// Port-level checks for the timed action table, bound to the top level.
// ----------------------------------------------------------------------------
`include "timed_action_table_defines.svh"

module tat_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [tat_pkg::ACTION_W-1:0]  req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tat_pkg::TCHAN_W-1:0]   rsp_out_channel,
   input logic [tat_pkg::TVAL_W-1:0]    rsp_out_value,
   input logic                          rsp_last
);
   import tat_pkg::*;

   // held word must not change
   `TAT_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel) && $stable(rsp_out_value) && $stable(rsp_last), "rsp word changed while stalled")

   // cancel and check occupy the block for a scan
   `TAT_ASSERT_CLK(a_scan_busy, clock, reset, req_valid && req_ready && (req_action == ACT_CANCEL || req_action == ACT_CHECK) |=> !req_ready, "request taken during scan")

   // schedule leaves the block ready for the next request
   `TAT_ASSERT_CLK(a_sched_fast, clock, reset, req_valid && req_ready && req_action == ACT_SCHEDULE |=> req_ready, "schedule held the block")

   // a non-final word means the check is still running
   `TAT_ASSERT_ALWAYS(a_last_pending, clock, rsp_valid && !rsp_last && !reset |-> !req_ready, "request taken before final word")

endmodule

bind timed_action_table tat_checker u_tat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_channel (rsp_out_channel),
   .rsp_out_value   (rsp_out_value),
   .rsp_last        (rsp_last)
);

// ===== test/timed_action_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_action_table_tb
// Self-checking bench for the timed action table: schedule, cancel and check
// words go in over valid/ready, and every expired entry that comes out is
// compared against an in-bench copy of the slot table. Both sides idle in
// random bursts; the result side is also held off long enough to back the
// block up.
// ----------------------------------------------------------------------------
module timed_action_table_tb;
   import tat_pkg::*;

   localparam int SLOTS          = ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS   = 285;
   localparam int QUIET_ITEMS    = 60;   // closing stretch with no idling
   localparam int LONG_HOLD      = 400;  // result-side hold-off, in cycles
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 2 * SLOTS + 8;

   // action 3 has no enum member; the block must ignore it
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [TIME_W-1:0]    now;
      logic [NOTE_CH_W-1:0] note_channel;
      logic [PITCH_W-1:0]   note_pitch;
      logic [TCHAN_W-1:0]   target_channel;
      logic [TVAL_W-1:0]    target_value;
      logic [DELAY_W-1:0]   delay;
   } timer_req_type;

   // one expected expiry word
   typedef struct packed {
      logic [TCHAN_W-1:0] channel;
      logic [TVAL_W-1:0]  value;
      logic               last;
   } fire_type;

   // -------------------------------------------------------------------------
   // Scoreboard: private copy of the slot table plus the queue of expiry
   // words still owed by the block.
   // -------------------------------------------------------------------------
   class expiry_scoreboard;
      bit                   live [SLOTS];
      logic [NOTE_CH_W-1:0] key_ch [SLOTS];
      logic [PITCH_W-1:0]   key_pitch [SLOTS];
      logic [TCHAN_W-1:0]   tgt_ch [SLOTS];
      logic [TVAL_W-1:0]    tgt_val [SLOTS];
      logic [TIME_W-1:0]    deadline [SLOTS];
      int unsigned          ring_ptr;
      fire_type             fires_due [$];

      int errors, n_sched, n_cancel, n_check, n_ignored, n_fired;
      int n_wrapped, n_overwrite, n_cancel_hits, biggest_check;

      function new();
         ring_ptr = 0;
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      function int pending();
         return fires_due.size();
      endfunction

      task report(input string what);
         errors++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      // Update the table for one accepted request word, queue its expiries.
      function void take_request(input timer_req_type w);
         int fired;
         fire_type f;
         fired = 0;
         case (w.action)
            ACT_SCHEDULE: begin
               n_sched++;
               if (live[ring_ptr]) n_overwrite++;
               live[ring_ptr]      = 1'b1;
               key_ch[ring_ptr]    = w.note_channel;
               key_pitch[ring_ptr] = w.note_pitch;
               tgt_ch[ring_ptr]    = w.target_channel;
               tgt_val[ring_ptr]   = w.target_value;
               deadline[ring_ptr]  = w.now + TIME_W'(w.delay);  // mod 2^32
               if (deadline[ring_ptr] < w.now) n_wrapped++;
               ring_ptr = (ring_ptr + 1) % SLOTS;
            end
            ACT_CANCEL: begin
               n_cancel++;
               for (int i = 0; i < SLOTS; i++)
                  if (live[i] && key_ch[i] == w.note_channel &&
                      key_pitch[i] == w.note_pitch) begin
                     live[i] = 1'b0;
                     n_cancel_hits++;
                  end
            end
            ACT_CHECK: begin
               n_check++;
               // index order, plain unsigned compare, capped per check
               for (int i = 0; i < SLOTS && fired < MAX_RESULTS; i++)
                  if (live[i] && deadline[i] <= w.now) begin
                     f.channel = tgt_ch[i];
                     f.value   = tgt_val[i];
                     f.last    = 1'b0;
                     fires_due.push_back(f);
                     live[i] = 1'b0;
                     fired++;
                  end
               if (fired > 0) fires_due[fires_due.size() - 1].last = 1'b1;
               if (fired > biggest_check) biggest_check = fired;
            end
            default: n_ignored++;
         endcase
      endfunction

      task check_fire(input logic [TCHAN_W-1:0] ch, input logic [TVAL_W-1:0] val,
                      input logic last);
         fire_type exp_f;
         if (fires_due.size() == 0) begin
            report($sformatf("unexpected word ch=%0d val=%0d last=%b", ch, val, last));
         end else begin
            exp_f = fires_due.pop_front();
            n_fired++;
            if (ch !== exp_f.channel)
               report($sformatf("out_channel %0d, want %0d", ch, exp_f.channel));
            if (val !== exp_f.value)
               report($sformatf("out_value %0d, want %0d", val, exp_f.value));
            if (last !== exp_f.last)
               report($sformatf("last %b, want %b", last, exp_f.last));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals
   // -------------------------------------------------------------------------
   logic                 clock, reset;
   logic                 req_valid, req_ready;
   logic [ACTION_W-1:0]  req_action;
   logic [TIME_W-1:0]    req_now;
   logic [NOTE_CH_W-1:0] req_note_channel;
   logic [PITCH_W-1:0]   req_note_pitch;
   logic [TCHAN_W-1:0]   req_target_channel;
   logic [TVAL_W-1:0]    req_target_value;
   logic [DELAY_W-1:0]   req_delay;
   logic                 rsp_valid, rsp_ready;
   logic [TCHAN_W-1:0]   rsp_out_channel;
   logic [TVAL_W-1:0]    rsp_out_value;
   logic                 rsp_last;

   timed_action_table #(.ENTRIES(SLOTS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_now            (req_now),
      .req_note_channel   (req_note_channel),
      .req_note_pitch     (req_note_pitch),
      .req_target_channel (req_target_channel),
      .req_target_value   (req_target_value),
      .req_delay          (req_delay),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_value      (rsp_out_value),
      .rsp_last           (rsp_last)
   );

   expiry_scoreboard sb = new();

   // knobs shared by the sender and the receiver
   int req_idle_pct = 10;
   int rsp_idle_pct = 10;
   bit no_idle      = 1'b0;
   bit hold_rsp_req = 1'b0;   // sender asks for the long result-side hold
   logic [TIME_W-1:0] wall_ms = 32'd1000;  // running millisecond clock

   int stall_cycles = 0;

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. Request words feed
   // the table copy, response words are checked against it.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.take_request('{req_action, req_now, req_note_channel, req_note_pitch,
                              req_target_channel, req_target_value, req_delay});
         if (rsp_valid && rsp_ready)
            sb.check_fire(rsp_out_channel, rsp_out_value, rsp_last);
      end
   end

   // Watchdog: any word moving on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: nothing moved for %0d cycles, %0d words owed",
                     $time, stall_cycles, sb.pending());
            $display("timed_action_table_tb failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold when asked, none at the end.
   // -------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            rsp_ready <= 1'b0;
            for (int n = 1; n < LONG_HOLD; n++) @(negedge clock);
            hold_rsp_req = 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks. send_word is entered at a falling edge and returns at the
   // falling edge after acceptance with valid still high, so a back-to-back
   // word never drops valid.
   // -------------------------------------------------------------------------
   function automatic timer_req_type make_word(
      input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
      input logic [NOTE_CH_W-1:0] ch, input logic [PITCH_W-1:0] pitch,
      input logic [TCHAN_W-1:0] tch, input logic [TVAL_W-1:0] tval,
      input logic [DELAY_W-1:0] dly);
      return '{act, now, ch, pitch, tch, tval, dly};
   endfunction

   task automatic send_word(input timer_req_type w);
      req_valid          <= 1'b1;
      req_action         <= w.action;
      req_now            <= w.now;
      req_note_channel   <= w.note_channel;
      req_note_pitch     <= w.note_pitch;
      req_target_channel <= w.target_channel;
      req_target_value   <= w.target_value;
      req_delay          <= w.delay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_word(input timer_req_type w);
      if (!no_idle && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      send_word(w);
   endtask

   // Pause the request side until every owed expiry word has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 8;
         default: return 25;
      endcase
   endfunction

   // Mostly well-formed traffic against a running clock: schedules with short
   // delays, checks that move time forward, cancels on a small key pool so
   // they hit. The rest is random noise, far deadlines and dropped actions.
   function automatic timer_req_type random_word();
      timer_req_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w = make_word(ACT_UNKNOWN, $urandom, NOTE_CH_W'($urandom), PITCH_W'($urandom),
                    TCHAN_W'($urandom), TVAL_W'($urandom), DELAY_W'($urandom));
      if ($urandom_range(0, 9) < 7) begin
         w.note_channel = NOTE_CH_W'($urandom_range(0, 3));
         w.note_pitch   = PITCH_W'($urandom_range(60, 63));
      end
      if (pick < 48) begin
         w.action = ACT_SCHEDULE;
         w.now    = wall_ms;
         case ($urandom_range(0, 19))
            0:       w.delay = 16'hFFFF;
            1:       w.delay = 16'd0;
            2, 3, 4: w.delay = DELAY_W'($urandom_range(0, 65535));
            default: w.delay = DELAY_W'($urandom_range(0, 300));
         endcase
      end else if (pick < 63) begin
         w.action = ACT_CANCEL;
      end else if (pick < 95) begin
         w.action = ACT_CHECK;
         if ($urandom_range(0, 32) == 0)
            wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);  // run up to the wrap
         else
            wall_ms = wall_ms + $urandom_range(0, 120);
         // a few checks at an arbitrary time
         w.now = ($urandom_range(0, 9) == 0) ? $urandom : wall_ms;
      end
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      timer_req_type w;
      int n_items;
      bit pressed, paused;

      n_items = 0;
      pressed = 1'b0;
      paused  = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_action         = ACT_SCHEDULE;
      req_now            = '0;
      req_note_channel   = '0;
      req_note_pitch     = '0;
      req_target_channel = '0;
      req_target_value   = '0;
      req_delay          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // empty table never fires, even at the top of time
      offer_word(make_word(ACT_CHECK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      // field extremes; second one wraps its deadline to 0xFFFE
      offer_word(make_word(ACT_SCHEDULE, 32'd0, 15, 127, 10'h3FF, 8'hFF, 16'd0));
      offer_word(make_word(ACT_SCHEDULE, 32'hFFFF_FFFF, 0, 0, 0, 0, 16'hFFFF));
      // two entries on one key, both go on a single cancel
      offer_word(make_word(ACT_SCHEDULE, 32'd100, 3, 60, 10'd512, 8'h5A, 16'd50));
      offer_word(make_word(ACT_SCHEDULE, 32'd100, 3, 60, 10'd1, 8'd1, 16'd10));
      // unknown action: would fire everything if it were taken as a check
      offer_word(make_word(ACT_UNKNOWN, 32'hFFFF_FFFF, 3, 60, 10'h3FF, 8'hFF, 16'hFFFF));
      offer_word(make_word(ACT_CANCEL, 32'd0, 3, 60, 0, 0, 0));
      offer_word(make_word(ACT_CHECK, 32'd0, 0, 0, 0, 0, 0));            // slot 0 only
      offer_word(make_word(ACT_CHECK, 32'h0000_FFFE, 0, 0, 0, 0, 0));    // wrapped one
      // fill every slot, then one more overwrites a live entry
      for (int k = 0; k <= SLOTS; k++)
         offer_word(make_word(ACT_SCHEDULE, 32'h8000_0000 + k, NOTE_CH_W'(k),
                              PITCH_W'(k * 7), TCHAN_W'(k * 61), TVAL_W'(k * 15),
                              DELAY_W'(k)));
      // full table expires in one check: maximum word count, last on the final one
      offer_word(make_word(ACT_CHECK, 32'h8000_0100, 0, 0, 0, 0, 0));

      // --- random ---
      while (n_items < RANDOM_ITEMS) begin
         if (n_items % 40 == 0 && n_items < RANDOM_ITEMS - QUIET_ITEMS) begin
            req_idle_pct = pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         if (n_items >= RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;

         if (!pressed && n_items >= 40) begin
            // hold results off while a full-table check is queued, then keep
            // offering words so the request side backs up
            pressed = 1'b1;
            hold_rsp_req = 1'b1;
            for (int k = 0; k < SLOTS; k++) begin
               w = random_word();
               w.action = ACT_SCHEDULE;
               w.now    = wall_ms;
               w.delay  = DELAY_W'($urandom_range(0, 3));
               offer_word(w);
            end
            offer_word(make_word(ACT_CHECK, wall_ms + 4, 0, 0, 0, 0, 0));
            n_items += SLOTS + 1;
         end

         if (!paused && n_items >= 160) begin
            paused = 1'b1;
            wait_drained();
         end

         w = random_word();
         offer_word(w);
         if (w.action != ACT_UNKNOWN) n_items++;
      end

      // --- wind down ---
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expiry words never came out", sb.pending()));

      $display("covered: %0d schedules (%0d overwrites, %0d wraps), %0d cancels (%0d hits)",
               sb.n_sched, sb.n_overwrite, sb.n_wrapped, sb.n_cancel, sb.n_cancel_hits);
      $display("covered: %0d checks, %0d ignored, %0d expiry words, up to %0d from one check",
               sb.n_check, sb.n_ignored, sb.n_fired, sb.biggest_check);
      if (sb.errors == 0)
         $display("timed_action_table_tb passed");
      else
         $display("timed_action_table_tb failed");
      $finish;
   end

endmodule

// ===== timed_action_table.f =====
+incdir+src
src/tat_pkg.sv
src/tat_ctrl.sv
src/tat_datapath.sv
src/timed_action_table.sv
src/tat_checker.sv
test/timed_action_table_tb.sv
